[src/ctd_pkg.sv]
`timescale 1ns / 1ps

package ctd_pkg;

    localparam int unsigned ID_W = 29;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_G0_ACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_G0_BRO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_G1_ACK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_G1_BRO = 2'd3;

    // Fixed device identifiers, acknowledged form. The broadcast form is ACK + 2.
    localparam logic [ID_W-1:0] CTRL0_ACK  = 29'h1E942040;
    localparam logic [ID_W-1:0] CTRL3_ACK  = 29'h1E94204C;
    localparam logic [ID_W-1:0] HMI0_ACK   = 29'h1E942C40;
    localparam logic [ID_W-1:0] ASSIST_REQ = 29'h02940015;
    localparam logic [ID_W-1:0] BAT1_ACK   = 29'h1E942444;
    localparam logic [ID_W-1:0] BAT6_ACK   = 29'h1E942458;
    localparam logic [ID_W-1:0] DERAIL_ACK = 29'h1E944840;
    localparam logic [ID_W-1:0] BRO_OFFSET = 29'd2;

    localparam logic [15:0] SPEED_INVALID = 16'hFFFF;
    localparam logic [7:0]  SOC_INVALID   = 8'hFF;
    localparam logic [3:0]  ASSIST_MAX    = 4'd5;
    localparam logic [3:0]  ASSIST_CLEAR  = 4'd6;
    localparam logic [8:0]  TEMP_OFFSET   = 9'd64;

    // Bit positions of the changed mask and the valid flags.
    localparam int unsigned BIT_SPEED   = 0;
    localparam int unsigned BIT_CADENCE = 1;
    localparam int unsigned BIT_ASSIST  = 2;
    localparam int unsigned BIT_SOC     = 3;
    localparam int unsigned BIT_VOLTAGE = 4;
    localparam int unsigned BIT_CURRENT = 5;
    localparam int unsigned BIT_TEMPS   = 6;
    localparam int unsigned BIT_GEAR    = 7;

    typedef enum logic [1:0] {
        ORG_NONE    = 2'd0,
        ORG_GENERAL = 2'd1,
        ORG_DEVICE  = 2'd2
    } t_origin;

    typedef struct packed {
        logic [ID_W-1:0] frame_id;
        logic [3:0]      frame_len;
        logic [63:0]     payload;
    } t_frame;

    typedef struct packed {
        logic [7:0]  changed_mask;
        logic [7:0]  valid_flags;
        logic [15:0] bike_speed;
        logic [7:0]  cadence_rpm;
        logic [2:0]  assist_level;
        logic [7:0]  battery_soc;
        logic [23:0] battery_voltage;
        logic [15:0] battery_current;
        logic [35:0] battery_temps;
        logic [7:0]  gear_index;
        logic [7:0]  gear_count;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [ID_W-1:0]      value;
    } t_cfg_write;

    typedef struct packed {
        logic [ID_W-1:0] g0_ack;
        logic [ID_W-1:0] g0_bro;
        logic [ID_W-1:0] g1_ack;
        logic [ID_W-1:0] g1_bro;
    } t_cfg_ids;

    typedef struct packed {
        logic [15:0]     speed_value;
        logic            speed_ok;
        t_origin         speed_origin;
        logic [7:0]      cadence_value;
        logic            cadence_ok;
        t_origin         cadence_origin;
        logic [2:0]      assist_value;
        logic            assist_ok;
        logic [7:0]      soc_value;
        logic            soc_ok;
        t_origin         soc_origin;
        logic [23:0]     voltage_value;
        logic            voltage_ok;
        logic [15:0]     current_value;
        logic            current_ok;
        logic [3:0][8:0] temp_values;
        logic            temps_ok;
        logic [7:0]      gear_now;
        logic [7:0]      gear_top;
        logic            gear_ok;
    } t_tlm_state;

endpackage

[src/ctd_stream_if.sv]
`timescale 1ns / 1ps

interface ctd_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/can_telemetry_frame_decoder.sv]
`timescale 1ns / 1ps

// CAN telemetry frame decoder. Each received CAN frame (29-bit identifier,
// length and eight payload bytes) arrives as one transfer on i_frame and
// yields exactly one transfer on o_result: the mask of quantities that this
// frame updated, the valid flags and the latest stored speed, cadence,
// assist level, state of charge, voltage, current, temperatures and gear.
// A frame is taken into an input register, decoded by a single level of
// compare and select logic, and its result lands in the output register
// together with the telemetry state, from where it is shown; one frame can
// be taken in every cycle as long as results are taken. The two stages
// stall independently, so a new frame is still accepted into a free input
// register while a result waits.
// The four general-info identifiers are written through i_cfg (index 0 to 3:
// general frame 0 ack and broadcast, general frame 1 ack and broadcast); the
// port is always ready and must only be written while no frame is in flight.
// The telemetry state, the identifiers and both valid bits clear on a synchronous active-low reset.
module can_telemetry_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctd_stream_if.sink   i_frame,
    ctd_stream_if.sink   i_cfg,
    ctd_stream_if.source o_result
);
    import ctd_pkg::*;

    t_cfg_ids   cfg_ids;

    // Input register stage.
    logic       r_in_valid;
    t_frame     r_in_frame;

    // Telemetry state and result register stage.
    t_tlm_state r_state;
    t_tlm_state n_state;
    logic [7:0] n_changed;
    logic       r_out_valid;
    t_result    r_result;
    t_result    n_result;
    logic       advance;

    ctd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_ids   (cfg_ids)
    );

    ctd_decode u_decode (
        .i_frame   (r_in_frame),
        .i_ids     (cfg_ids),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_changed (n_changed)
    );

    // The held frame moves on when the result register is empty or its
    // result is being taken in this cycle.
    assign advance       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_frame.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_in_frame <= i_frame.data;
        end
    end

    always_comb begin
        n_result.changed_mask    = n_changed;
        n_result.valid_flags     = {n_state.gear_ok, n_state.temps_ok, n_state.current_ok,
                                    n_state.voltage_ok, n_state.soc_ok, n_state.assist_ok,
                                    n_state.cadence_ok, n_state.speed_ok};
        n_result.bike_speed      = n_state.speed_value;
        n_result.cadence_rpm     = n_state.cadence_value;
        n_result.assist_level    = n_state.assist_value;
        n_result.battery_soc     = n_state.soc_value;
        n_result.battery_voltage = n_state.voltage_value;
        n_result.battery_current = n_state.current_value;
        n_result.battery_temps   = n_state.temp_values;
        n_result.gear_index      = n_state.gear_now;
        n_result.gear_count      = n_state.gear_top;
    end

    // State and result update together, so the result always shows the
    // state as this frame left it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_result;

    // A quantity reported as changed must also be reported as valid.
    a_changed_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_result.changed_mask & ~r_result.valid_flags) == 8'd0))
        else $error("changed quantity without valid flag");

    // The invalid-speed marker is never stored.
    a_speed_not_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.bike_speed != SPEED_INVALID))
        else $error("invalid speed marker stored");

    // The assist level never exceeds five.
    a_assist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.assist_level <= ASSIST_MAX[2:0]))
        else $error("assist level out of range");

    // A frame held in the input register with a free result register moves on.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("frame did not advance to result register");
endmodule

[src/ctd_cfg_regs.sv]
`timescale 1ns / 1ps

module ctd_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ctd_stream_if.sink        i_cfg,
    output ctd_pkg::t_cfg_ids o_ids
);
    import ctd_pkg::*;

    t_cfg_ids r_ids;

    assign i_cfg.ready = 1'b1;
    assign o_ids       = r_ids;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_G0_ACK: begin
                    r_ids.g0_ack <= i_cfg.data.value;
                end
                CFG_G0_BRO: begin
                    r_ids.g0_bro <= i_cfg.data.value;
                end
                CFG_G1_ACK: begin
                    r_ids.g1_ack <= i_cfg.data.value;
                end
                CFG_G1_BRO: begin
                    r_ids.g1_bro <= i_cfg.data.value;
                end
                default: begin
                end
            endcase
        end
    end
endmodule

[src/ctd_decode.sv]
`timescale 1ns / 1ps

module ctd_decode (
    input  ctd_pkg::t_frame     i_frame,
    input  ctd_pkg::t_cfg_ids   i_ids,
    input  ctd_pkg::t_tlm_state i_state,
    output ctd_pkg::t_tlm_state o_state,
    output logic [7:0]          o_changed
);
    import ctd_pkg::*;

    logic [7:0][7:0] b;
    logic [ID_W-1:0] id;
    logic [3:0]      len;
    logic [15:0]     sp;
    logic [3:0]      level;
    logic            do_assist;

    assign b   = i_frame.payload;
    assign id  = i_frame.frame_id;
    assign len = i_frame.frame_len;

    function automatic logic is_pair(input logic [ID_W-1:0] fid, input logic [ID_W-1:0] ack);
        return (fid == ack) || (fid == ack + BRO_OFFSET);
    endfunction

    always_comb begin
        o_state   = i_state;
        o_changed = '0;
        sp        = {b[1], b[0]};
        level     = '0;
        do_assist = 1'b0;

        if (id == i_ids.g0_ack || id == i_ids.g0_bro) begin
            if (len >= 4'd6) begin
                if (sp != SPEED_INVALID) begin
                    o_state.speed_value  = sp;
                    o_state.speed_ok     = 1'b1;
                    o_state.speed_origin = ORG_GENERAL;
                    o_changed[BIT_SPEED] = 1'b1;
                end else begin
                    o_state.speed_ok     = 1'b0;
                    o_state.speed_origin = ORG_NONE;
                end
                o_state.cadence_value  = b[4];
                o_state.cadence_ok     = 1'b1;
                o_state.cadence_origin = ORG_GENERAL;
                o_changed[BIT_CADENCE] = 1'b1;
                level     = b[5][5:2];
                do_assist = 1'b1;
            end
        end else if (id == i_ids.g1_ack || id == i_ids.g1_bro) begin
            if (len >= 4'd5) begin
                if (b[4] != SOC_INVALID) begin
                    o_state.soc_value  = b[4];
                    o_state.soc_ok     = 1'b1;
                    o_state.soc_origin = ORG_GENERAL;
                    o_changed[BIT_SOC] = 1'b1;
                end else begin
                    o_state.soc_ok     = 1'b0;
                    o_state.soc_origin = ORG_NONE;
                end
            end
        end else if (is_pair(id, HMI0_ACK)) begin
            if (len >= 4'd1) begin
                level     = b[0][3:0];
                do_assist = 1'b1;
            end
        end else if (id == ASSIST_REQ) begin
            if (len >= 4'd2) begin
                level     = b[1][3:0];
                do_assist = 1'b1;
            end
        end else if (is_pair(id, CTRL0_ACK)) begin
            if (len >= 4'd2 && i_state.speed_origin != ORG_GENERAL
                    && sp != SPEED_INVALID) begin
                o_state.speed_value  = sp;
                o_state.speed_ok     = 1'b1;
                o_state.speed_origin = ORG_DEVICE;
                o_changed[BIT_SPEED] = 1'b1;
            end
        end else if (is_pair(id, CTRL3_ACK)) begin
            if (len >= 4'd4 && i_state.cadence_origin != ORG_GENERAL) begin
                o_state.cadence_value  = b[3];
                o_state.cadence_ok     = 1'b1;
                o_state.cadence_origin = ORG_DEVICE;
                o_changed[BIT_CADENCE] = 1'b1;
            end
        end else if (is_pair(id, BAT1_ACK)) begin
            if (len >= 4'd7) begin
                o_state.voltage_value  = {b[2], b[1], b[0]};
                o_state.voltage_ok     = 1'b1;
                o_state.current_value  = {b[5], b[4]};
                o_state.current_ok     = 1'b1;
                o_changed[BIT_VOLTAGE] = 1'b1;
                o_changed[BIT_CURRENT] = 1'b1;
                if (i_state.soc_origin != ORG_GENERAL && b[6] != SOC_INVALID) begin
                    o_state.soc_value  = b[6];
                    o_state.soc_ok     = 1'b1;
                    o_state.soc_origin = ORG_DEVICE;
                    o_changed[BIT_SOC] = 1'b1;
                end
            end
        end else if (is_pair(id, BAT6_ACK)) begin
            if (len >= 4'd4) begin
                for (int i = 0; i < 4; i++) begin
                    o_state.temp_values[i] = {1'b0, b[i]} - TEMP_OFFSET;
                end
                o_state.temps_ok     = 1'b1;
                o_changed[BIT_TEMPS] = 1'b1;
            end
        end else if (is_pair(id, DERAIL_ACK)) begin
            if (len >= 4'd2) begin
                o_state.gear_now    = b[0];
                o_state.gear_top    = b[1];
                o_state.gear_ok     = 1'b1;
                o_changed[BIT_GEAR] = 1'b1;
            end
        end

        // Levels up to five are stored, six only drops the valid flag.
        if (do_assist) begin
            if (level <= ASSIST_MAX) begin
                o_state.assist_value  = level[2:0];
                o_state.assist_ok     = 1'b1;
                o_changed[BIT_ASSIST] = 1'b1;
            end else if (level == ASSIST_CLEAR) begin
                o_state.assist_ok = 1'b0;
            end
        end
    end
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the CAN telemetry frame decoder.
//
// Frames go in on the frame channel, identifier settings on the config channel,
// and every frame must come back as exactly one result transfer. A local decoder
// model keeps its own copy of the telemetry state and of the four general-info
// identifiers, and predicts each result when its frame transfer is seen. Results
// are checked field by field, in order, against the oldest prediction.
module testbench;
    import ctd_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 500_000;
    localparam int unsigned ITEMS_PER_PHASE = 300;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned SHOWN_FAULTS    = 10;
    localparam int unsigned MAX_WAIT        = 13;

    // Fixed device identifiers in acknowledged form, used to aim random frames.
    localparam logic [ID_W-1:0] DEVICE_IDS [7] = '{
        CTRL0_ACK, CTRL3_ACK, HMI0_ACK, ASSIST_REQ, BAT1_ACK, BAT6_ACK, DERAIL_ACK
    };

    // General-info identifiers used by the directed script from SCRIPT_SPLIT on and by the first random phase.
    localparam t_cfg_ids DIRECTED_IDS = '{
        29'h0ABCDE10, 29'h0ABCDE12, 29'h15555555, 29'h0AAAAAAA
    };

    // One row of the directed script. When typed is set, answer is the result
    // written down by hand; otherwise the local decoder model supplies it.
    typedef struct packed {
        t_frame  frame;
        bit      typed;
        t_result answer;
    } t_script_row;

    typedef struct packed {
        bit      typed;
        t_result answer;
    } t_answer_hint;

    localparam int unsigned SCRIPT_LEN   = 26;
    localparam int unsigned SCRIPT_SPLIT = 21;

    // The first rows run right after reset, where all four general-info
    // identifiers are zero, so identifier 0 acts as general frame 0 and also
    // shadows general frame 1. From SCRIPT_SPLIT on, DIRECTED_IDS is active.
    t_script_row script [SCRIPT_LEN] = '{
        // Unknown identifier with a full payload: nothing changes, all zero.
        '{'{29'h1FFFFFFF, 4'd8, '1}, 1'b1, '0},
        // Rear gear at its top values.
        '{'{DERAIL_ACK, 4'd2, '1}, 1'b1,
          '{8'h80, 8'h80, 16'h0, 8'h0, 3'h0, 8'h0, 24'h0, 16'h0, 36'h0, 8'hFF, 8'hFF}},
        // Temperatures from all-zero bytes land at the bottom, -64.
        '{'{BAT6_ACK, 4'd4, '0}, 1'b1,
          '{8'h40, 8'hC0, 16'h0, 8'h0, 3'h0, 8'h0, 24'h0, 16'h0, {4{9'h1C0}},
            8'hFF, 8'hFF}},
        // Broadcast form, all bytes 0xFF and a length beyond eight: top is 191.
        '{'{BAT6_ACK + BRO_OFFSET, 4'd15, '1}, 1'b1,
          '{8'h40, 8'hC0, 16'h0, 8'h0, 3'h0, 8'h0, 24'h0, 16'h0, {4{9'h0BF}},
            8'hFF, 8'hFF}},
        // Device cadence while no general frame has been seen.
        '{'{CTRL3_ACK, 4'd4, 64'h0000_0000_AB00_0000}, 1'b0, '0},
        // General frame 0 at its minimum length: speed, cadence, assist 3.
        '{'{29'h0, 4'd6, 64'h0000_0C56_0000_1234}, 1'b0, '0},
        // Device speed while the speed source is general info: ignored.
        '{'{CTRL0_ACK, 4'd8, 64'h0000_0000_0000_0777}, 1'b0, '0},
        // General frame 0 one byte short.
        '{'{29'h0, 4'd5, '1}, 1'b0, '0},
        // General speed marker invalidates speed, assist level 6 clears assist.
        '{'{29'h0, 4'd8, 64'h0000_18FF_0000_FFFF}, 1'b0, '0},
        // Device speed marker in broadcast form: ignored.
        '{'{CTRL0_ACK + BRO_OFFSET, 4'd2, '1}, 1'b0, '0},
        // Device speed zero, now allowed since the source was cleared.
        '{'{CTRL0_ACK, 4'd2, 64'hFFFF_FFFF_FFFF_0000}, 1'b0, '0},
        // Device cadence while the cadence source is general info: ignored.
        '{'{CTRL3_ACK, 4'd8, 64'h0000_0000_5500_0000}, 1'b0, '0},
        // HMI assist at the top level, then an out-of-range level.
        '{'{HMI0_ACK, 4'd1, 64'h0000_0000_0000_0005}, 1'b0, '0},
        '{'{HMI0_ACK + BRO_OFFSET, 4'd8, 64'h0000_0000_0000_0007}, 1'b0, '0},
        // Assist request with level 15 (ignored) and with level 0.
        '{'{ASSIST_REQ, 4'd2, 64'h0000_0000_0000_0F00}, 1'b0, '0},
        '{'{ASSIST_REQ, 4'd2, 64'h0000_0000_0000_F000}, 1'b0, '0},
        // Battery at full scale with the state-of-charge marker.
        '{'{BAT1_ACK, 4'd7, 64'h00FF_FFFF_FFFF_FFFF}, 1'b0, '0},
        // Battery broadcast, zero voltage and current, charge from the device.
        '{'{BAT1_ACK + BRO_OFFSET, 4'd8, 64'h0064_0000_0000_0000}, 1'b0, '0},
        // Battery one byte short, gear with length zero, a near-miss identifier.
        '{'{BAT1_ACK, 4'd6, 64'h0012_3456_789A_BCDE}, 1'b0, '0},
        '{'{DERAIL_ACK + BRO_OFFSET, 4'd0, '1}, 1'b0, '0},
        '{'{DERAIL_ACK + 29'd1, 4'd8, '1}, 1'b0, '0},
        // From here on the directed identifier setting is active.
        // General charge marker clears charge and its source.
        '{'{DIRECTED_IDS.g1_ack, 4'd5, 64'h0000_00FF_0000_0000}, 1'b0, '0},
        // Device charge is taken again.
        '{'{BAT1_ACK, 4'd8, 64'h0032_1111_0022_3344}, 1'b0, '0},
        // General charge at its top value, then device charge is ignored.
        '{'{DIRECTED_IDS.g1_bro, 4'd8, 64'h0000_00FE_0000_0000}, 1'b0, '0},
        '{'{BAT1_ACK, 4'd7, 64'h0010_0000_0000_0000}, 1'b0, '0},
        // General frame 0 through its broadcast identifier, top valid speed.
        '{'{DIRECTED_IDS.g0_bro, 4'd6, 64'h0000_0000_0000_FFFE}, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctd_stream_if #(.t_data(t_frame))     frame_if ();
    ctd_stream_if #(.t_data(t_cfg_write)) cfg_if ();
    ctd_stream_if #(.t_data(t_result))    result_if ();

    can_telemetry_frame_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    // Local copy of what the decoder should hold.
    t_tlm_state telemetry;
    t_cfg_ids   general_ids;

    t_result      expected_results [$];
    t_answer_hint answer_hints [$];

    int unsigned cycle_count     = 0;
    int unsigned frames_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned error_count     = 0;
    int unsigned settings_used   = 1;
    int unsigned long_holds      = 0;

    // Pacing controls. A calm side does not idle at all.
    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;
    bit hold_request  = 1'b0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic void report_fault(input string text);
        error_count++;
        if (error_count <= SHOWN_FAULTS) begin
            $display("[%0d] %s", cycle_count, text);
        end
    endfunction

    function automatic void diff_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got, inout string diffs);
        if (got !== want) begin
            diffs = {diffs, $sformatf(" %s exp=%0h act=%0h", name, want, got)};
        end
    endfunction

    function automatic bit id_pair(input logic [ID_W-1:0] id, input logic [ID_W-1:0] ack);
        logic [ID_W-1:0] bro;
        bro = ack + BRO_OFFSET;
        return (id == ack) || (id == bro);
    endfunction

    // Levels 0..5 are stored, level 6 only drops the valid flag, the rest
    // leave the assist level alone.
    function automatic logic [7:0] take_assist(input logic [3:0] level);
        logic [7:0] hit;
        hit = '0;
        if (level <= ASSIST_MAX) begin
            telemetry.assist_value = level[2:0];
            telemetry.assist_ok = 1'b1;
            hit[BIT_ASSIST] = 1'b1;
        end else if (level == ASSIST_CLEAR) begin
            telemetry.assist_ok = 1'b0;
        end
        return hit;
    endfunction

    // Decodes one frame into the local telemetry state and forms its result.
    // The identifier tests run in priority order: general frame 0, general
    // frame 1, then the fixed device identifiers.
    function automatic t_result decode_frame(input t_frame f);
        logic [7:0]  b [8];
        logic [15:0] speed_word;
        logic [7:0]  hit;
        t_result     r;
        hit = '0;
        for (int i = 0; i < 8; i++) begin
            b[i] = f.payload[8*i +: 8];
        end
        speed_word = {b[1], b[0]};

        if (f.frame_id == general_ids.g0_ack || f.frame_id == general_ids.g0_bro) begin
            if (f.frame_len >= 4'd6) begin
                if (speed_word != SPEED_INVALID) begin
                    telemetry.speed_value = speed_word;
                    telemetry.speed_ok = 1'b1;
                    telemetry.speed_origin = ORG_GENERAL;
                    hit[BIT_SPEED] = 1'b1;
                end else begin
                    telemetry.speed_ok = 1'b0;
                    telemetry.speed_origin = ORG_NONE;
                end
                telemetry.cadence_value = b[4];
                telemetry.cadence_ok = 1'b1;
                telemetry.cadence_origin = ORG_GENERAL;
                hit[BIT_CADENCE] = 1'b1;
                hit |= take_assist(b[5][5:2]);
            end
        end else if (f.frame_id == general_ids.g1_ack || f.frame_id == general_ids.g1_bro) begin
            if (f.frame_len >= 4'd5) begin
                if (b[4] != SOC_INVALID) begin
                    telemetry.soc_value = b[4];
                    telemetry.soc_ok = 1'b1;
                    telemetry.soc_origin = ORG_GENERAL;
                    hit[BIT_SOC] = 1'b1;
                end else begin
                    telemetry.soc_ok = 1'b0;
                    telemetry.soc_origin = ORG_NONE;
                end
            end
        end else if (id_pair(f.frame_id, HMI0_ACK)) begin
            if (f.frame_len >= 4'd1) begin
                hit |= take_assist(b[0][3:0]);
            end
        end else if (f.frame_id == ASSIST_REQ) begin
            if (f.frame_len >= 4'd2) begin
                hit |= take_assist(b[1][3:0]);
            end
        end else if (id_pair(f.frame_id, CTRL0_ACK)) begin
            // Device speed yields to general info and never takes the marker.
            if (f.frame_len >= 4'd2 && telemetry.speed_origin != ORG_GENERAL &&
                speed_word != SPEED_INVALID) begin
                telemetry.speed_value = speed_word;
                telemetry.speed_ok = 1'b1;
                telemetry.speed_origin = ORG_DEVICE;
                hit[BIT_SPEED] = 1'b1;
            end
        end else if (id_pair(f.frame_id, CTRL3_ACK)) begin
            if (f.frame_len >= 4'd4 && telemetry.cadence_origin != ORG_GENERAL) begin
                telemetry.cadence_value = b[3];
                telemetry.cadence_ok = 1'b1;
                telemetry.cadence_origin = ORG_DEVICE;
                hit[BIT_CADENCE] = 1'b1;
            end
        end else if (id_pair(f.frame_id, BAT1_ACK)) begin
            if (f.frame_len >= 4'd7) begin
                telemetry.voltage_value = {b[2], b[1], b[0]};
                telemetry.voltage_ok = 1'b1;
                telemetry.current_value = {b[5], b[4]};
                telemetry.current_ok = 1'b1;
                hit[BIT_VOLTAGE] = 1'b1;
                hit[BIT_CURRENT] = 1'b1;
                if (telemetry.soc_origin != ORG_GENERAL && b[6] != SOC_INVALID) begin
                    telemetry.soc_value = b[6];
                    telemetry.soc_ok = 1'b1;
                    telemetry.soc_origin = ORG_DEVICE;
                    hit[BIT_SOC] = 1'b1;
                end
            end
        end else if (id_pair(f.frame_id, BAT6_ACK)) begin
            if (f.frame_len >= 4'd4) begin
                for (int i = 0; i < 4; i++) begin
                    telemetry.temp_values[i] = {1'b0, b[i]} - TEMP_OFFSET;
                end
                telemetry.temps_ok = 1'b1;
                hit[BIT_TEMPS] = 1'b1;
            end
        end else if (id_pair(f.frame_id, DERAIL_ACK)) begin
            if (f.frame_len >= 4'd2) begin
                telemetry.gear_now = b[0];
                telemetry.gear_top = b[1];
                telemetry.gear_ok = 1'b1;
                hit[BIT_GEAR] = 1'b1;
            end
        end

        r.changed_mask = hit;
        r.valid_flags = '0;
        r.valid_flags[BIT_SPEED]   = telemetry.speed_ok;
        r.valid_flags[BIT_CADENCE] = telemetry.cadence_ok;
        r.valid_flags[BIT_ASSIST]  = telemetry.assist_ok;
        r.valid_flags[BIT_SOC]     = telemetry.soc_ok;
        r.valid_flags[BIT_VOLTAGE] = telemetry.voltage_ok;
        r.valid_flags[BIT_CURRENT] = telemetry.current_ok;
        r.valid_flags[BIT_TEMPS]   = telemetry.temps_ok;
        r.valid_flags[BIT_GEAR]    = telemetry.gear_ok;
        r.bike_speed      = telemetry.speed_value;
        r.cadence_rpm     = telemetry.cadence_value;
        r.assist_level    = telemetry.assist_value;
        r.battery_soc     = telemetry.soc_value;
        r.battery_voltage = telemetry.voltage_value;
        r.battery_current = telemetry.current_value;
        r.battery_temps   = telemetry.temp_values;
        r.gear_index      = telemetry.gear_now;
        r.gear_count      = telemetry.gear_top;
        return r;
    endfunction

    // Random frames are mostly aimed at identifiers the decoder knows, with
    // lengths that usually pass, and payloads salted with the invalid markers
    // and with assist levels around the boundary between 5, 6 and 7.
    function automatic t_frame random_frame();
        t_frame      f;
        int unsigned pick;
        int unsigned len_pick;
        logic [3:0]  level;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            f.frame_id = general_ids.g0_ack;
        end else if (pick < 16) begin
            f.frame_id = general_ids.g0_bro;
        end else if (pick < 22) begin
            f.frame_id = general_ids.g1_ack;
        end else if (pick < 28) begin
            f.frame_id = general_ids.g1_bro;
        end else if (pick < 72) begin
            f.frame_id = DEVICE_IDS[$urandom_range(0, 6)];
            if ($urandom_range(0, 1) == 1) begin
                f.frame_id = f.frame_id + BRO_OFFSET;
            end
        end else if (pick < 84) begin
            // Near misses from one below to three above an acknowledged form.
            f.frame_id = DEVICE_IDS[$urandom_range(0, 6)] + ID_W'($urandom_range(0, 4))
                         - ID_W'(1);
        end else begin
            f.frame_id = ID_W'($urandom);
        end

        len_pick = $urandom_range(0, 19);
        if (len_pick < 14) begin
            f.frame_len = 4'd8;
        end else if (len_pick < 17) begin
            f.frame_len = 4'($urandom_range(0, 7));
        end else begin
            f.frame_len = 4'($urandom_range(9, 15));
        end

        f.payload = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) begin
            f.payload[15:0] = SPEED_INVALID;
        end
        if ($urandom_range(0, 9) == 0) begin
            f.payload[39:32] = SOC_INVALID;
        end
        if ($urandom_range(0, 9) == 0) begin
            f.payload[55:48] = SOC_INVALID;
        end
        if ($urandom_range(0, 1) == 0) begin
            level = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(5, 7)) : 4'($urandom);
            f.payload[45:42] = level;
            f.payload[11:8] = level;
            f.payload[3:0] = level;
        end
        return f;
    endfunction

    // Offers one frame after a random gap and returns once it is transferred.
    // With no gap, valid simply stays high into the next frame.
    task automatic send_frame(input t_frame f, input bit typed, input t_result answer);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        answer_hints.push_back('{typed, answer});
        if (gap > 0) begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_if.valid <= 1'b1;
        frame_if.data <= f;
        do @(posedge i_clk); while (!frame_if.ready);
        frames_sent++;
    endtask

    // Stops offering frames and waits until every predicted result is back.
    task automatic settle();
        frame_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [ID_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{index: index, value: value};
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Writes all four general-info identifiers back to back. Only called
    // while no frame is in flight, so the local copy can follow at once.
    task automatic program_ids(input t_cfg_ids setting);
        write_reg(CFG_G0_ACK, setting.g0_ack);
        write_reg(CFG_G0_BRO, setting.g0_bro);
        write_reg(CFG_G1_ACK, setting.g1_ack);
        write_reg(CFG_G1_BRO, setting.g1_bro);
        cfg_if.valid <= 1'b0;
        general_ids = setting;
        settings_used++;
    endtask

    // Run-time guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: each result gets its own random hold-off, with calm
    // stretches where ready stays high, and once a long stall on request so
    // that the decoder backs up and stops taking frames.
    initial begin : result_sink
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        result_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
                long_holds++;
            end else begin
                hold = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold > 0) begin
                result_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (!result_if.valid);
            taken++;
            if (taken % 50 == 0) begin
                receiver_calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watches both channels. A result transfer is checked before a frame
    // transfer in the same cycle is predicted, since the decoder cannot
    // answer a frame in the cycle it takes it.
    always @(posedge i_clk) begin : scoreboard
        t_result      want;
        t_result      got;
        t_result      predicted;
        t_answer_hint hint;
        string        diffs;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                got = result_if.data;
                results_checked++;
                if (expected_results.size() == 0) begin
                    report_fault($sformatf("Unexpected result transfer: %h", got));
                end else begin
                    want = expected_results.pop_front();
                    diffs = "";
                    diff_field("changed_mask", 64'(want.changed_mask),
                               64'(got.changed_mask), diffs);
                    diff_field("valid_flags", 64'(want.valid_flags),
                               64'(got.valid_flags), diffs);
                    diff_field("bike_speed", 64'(want.bike_speed),
                               64'(got.bike_speed), diffs);
                    diff_field("cadence_rpm", 64'(want.cadence_rpm),
                               64'(got.cadence_rpm), diffs);
                    diff_field("assist_level", 64'(want.assist_level),
                               64'(got.assist_level), diffs);
                    diff_field("battery_soc", 64'(want.battery_soc),
                               64'(got.battery_soc), diffs);
                    diff_field("battery_voltage", 64'(want.battery_voltage),
                               64'(got.battery_voltage), diffs);
                    diff_field("battery_current", 64'(want.battery_current),
                               64'(got.battery_current), diffs);
                    diff_field("battery_temps", 64'(want.battery_temps),
                               64'(got.battery_temps), diffs);
                    diff_field("gear_index", 64'(want.gear_index),
                               64'(got.gear_index), diffs);
                    diff_field("gear_count", 64'(want.gear_count),
                               64'(got.gear_count), diffs);
                    if (diffs != "") begin
                        report_fault($sformatf("Result %0d mismatch:%s", results_checked, diffs));
                    end
                end
            end
            if (frame_if.valid && frame_if.ready) begin
                predicted = decode_frame(frame_if.data);
                hint = answer_hints.pop_front();
                expected_results.push_back(hint.typed ? hint.answer : predicted);
            end
        end
    end

    initial begin : stimulus
        t_cfg_ids        setting;
        logic [ID_W-1:0] base;
        telemetry = '0;
        general_ids = '0;
        i_rst_n <= 1'b0;
        frame_if.valid <= 1'b0;
        frame_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script: reset identifiers first, then a known setting.
        for (int k = 0; k < SCRIPT_LEN; k++) begin
            if (k == SCRIPT_SPLIT) begin
                settle();
                program_ids(DIRECTED_IDS);
            end
            send_frame(script[k].frame, script[k].typed, script[k].answer);
        end

        // Random phases, each under its own identifier setting: the directed
        // one, all ones, general identifiers that shadow device identifiers,
        // random values, all zeros, and a random ack/broadcast pair.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: setting = '1;
                    2: setting = '{CTRL0_ACK, HMI0_ACK + BRO_OFFSET, BAT1_ACK, ASSIST_REQ};
                    3: setting = '{ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                                   ID_W'($urandom)};
                    4: setting = '0;
                    default: begin
                        base = ID_W'($urandom);
                        setting = '{base, base + BRO_OFFSET, base ^ ID_W'(1),
                                    ID_W'($urandom)};
                    end
                endcase
                settle();
                program_ids(setting);
            end
            // In the third phase the result side stalls for a long stretch
            // while frames keep coming back to back.
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 100 == 0) begin
                    sender_calm = (phase == 2 && n == 0) || ($urandom_range(0, 3) == 0);
                end
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("Run: %0d frames sent, %0d results compared, %0d identifier settings.",
                 frames_sent, results_checked, settings_used);
        $display("Run: %0d long output stalls, %0d faults found.", long_holds, error_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
